// File: sv/tpsc_pkg.sv
// Package for the tile parameter stream classifier.
// Holds the word types, state record, code constants and the lookup functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tpsc_pkg;

  localparam logic OP_CHUNK     = 1'b0;
  localparam logic OP_LIST_INIT = 1'b1;

  localparam logic [2:0] PK_END_LIST  = 3'd0;
  localparam logic [2:0] PK_TILE_CLIP = 3'd1;
  localparam logic [2:0] PK_LIST_SET  = 3'd2;
  localparam logic [2:0] PK_POLY      = 3'd3;
  localparam logic [2:0] PK_SPRITE    = 3'd4;
  localparam logic [2:0] PK_VERTEX    = 3'd5;

  localparam logic [2:0] LK_OPAQUE_MV = 3'd1;
  localparam logic [2:0] LK_TRANS_MV  = 3'd3;
  localparam logic [2:0] LK_LAST      = 3'd4;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_LIST_SET = 2'd1;
  localparam logic [1:0] ERR_INVALID  = 2'd2;

  localparam logic [6:0] BYTES_NONE = 7'd0;
  localparam logic [6:0] BYTES_32   = 7'd32;
  localparam logic [6:0] BYTES_64   = 7'd64;

  localparam logic [4:0] VK_MODVOL    = 5'd17;
  localparam logic [4:0] VK_SPRITE_TX = 5'd16;
  localparam logic [4:0] VK_SPRITE    = 5'd15;

  typedef struct packed {
    logic       operation;
    logic [2:0] para_kind;
    logic [2:0] list_kind;
    logic [1:0] color_type;
    logic       textured;
    logic       offset_color;
    logic       two_volume;
    logic       uv_half;
  } chunk_t;

  typedef struct packed {
    logic       param_done;
    logic [6:0] param_bytes;
    logic [4:0] vertex_kind;
    logic       irq_valid;
    logic [2:0] irq_list;
    logic [1:0] error_code;
  } result_t;

  // Control-word fields kept from the first chunk of a 64-byte parameter.
  typedef struct packed {
    logic [2:0] para_kind;
    logic [2:0] list_kind;
    logic [1:0] color_type;
    logic       textured;
    logic       offset_color;
    logic       two_volume;
    logic       uv_half;
  } fields_t;

  typedef struct packed {
    logic       half_pending;
    fields_t    held;
    logic [2:0] list;
    logic [4:0] vertex_kind;
  } state_t;

  function automatic logic [4:0] vertex_class(input fields_t f);
    logic [4:0] vk;
    vk = 5'd0;
    if (f.list_kind == LK_OPAQUE_MV || f.list_kind == LK_TRANS_MV) begin
      vk = VK_MODVOL;
    end else if (f.para_kind == PK_SPRITE) begin
      vk = f.textured ? VK_SPRITE_TX : VK_SPRITE;
    end else if (f.two_volume && f.textured && f.color_type == 2'd0) begin
      vk = f.uv_half ? 5'd12 : 5'd11;
    end else if (f.two_volume && f.textured && f.color_type inside {2'd2, 2'd3}) begin
      vk = f.uv_half ? 5'd14 : 5'd13;
    end else if (f.two_volume && f.color_type == 2'd0) begin
      vk = 5'd9;
    end else if (f.two_volume && f.color_type inside {2'd2, 2'd3}) begin
      vk = 5'd10;
    end else if (f.textured) begin
      case (f.color_type)
        2'd0:    vk = f.uv_half ? 5'd4 : 5'd3;
        2'd1:    vk = f.uv_half ? 5'd6 : 5'd5;
        default: vk = f.uv_half ? 5'd8 : 5'd7;
      endcase
    end else begin
      case (f.color_type)
        2'd0:    vk = 5'd0;
        2'd1:    vk = 5'd1;
        default: vk = 5'd2;
      endcase
    end
    return vk;
  endfunction

  // Size of a parameter from its first chunk; the list type plays no part.
  function automatic logic [6:0] param_size(input fields_t f, input logic [4:0] vk);
    logic [6:0] size;
    logic       wide_poly;
    wide_poly = (f.color_type == 2'd2) && (f.two_volume || (f.textured && f.offset_color));
    case (f.para_kind)
      PK_END_LIST, PK_TILE_CLIP, PK_LIST_SET, PK_SPRITE: size = BYTES_32;
      PK_POLY:   size = wide_poly ? BYTES_64 : BYTES_32;
      PK_VERTEX: size = (vk inside {[5'd0:5'd4], [5'd7:5'd10]}) ? BYTES_32 : BYTES_64;
      default:   size = BYTES_NONE;
    endcase
    return size;
  endfunction

endpackage

`default_nettype wire

// File: sv/tpsc_in_if.sv
// Input channel of the classifier: valid/ready handshake with one chunk word.
// Depends on tpsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tpsc_in_if;
  import tpsc_pkg::*;
  logic   valid;
  logic   ready;
  chunk_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/tpsc_out_if.sv
// Output channel of the classifier: valid/ready handshake with one result word.
// Depends on tpsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tpsc_out_if;
  import tpsc_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/tpsc_step.sv
// Combinational step of the classifier: next parse state and result for one word.
// Depends on tpsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpsc_step (
  input  tpsc_pkg::chunk_t  chunk,
  input  tpsc_pkg::state_t  state,
  output tpsc_pkg::state_t  state_next,
  output tpsc_pkg::result_t res
);
  import tpsc_pkg::*;

  fields_t    in_f;
  fields_t    f;
  logic [6:0] size;
  logic       complete;

  assign in_f = '{para_kind: chunk.para_kind, list_kind: chunk.list_kind,
                  color_type: chunk.color_type, textured: chunk.textured,
                  offset_color: chunk.offset_color, two_volume: chunk.two_volume,
                  uv_half: chunk.uv_half};

  assign f    = state.half_pending ? state.held : in_f;
  assign size = state.half_pending ? BYTES_64 : param_size(in_f, state.vertex_kind);
  assign complete = (size != BYTES_NONE) && (state.half_pending || size != BYTES_64);

  always_comb begin
    state_next = state;
    res = '0;
    if (chunk.operation == OP_LIST_INIT) begin
      state_next = '0;
    end else begin
      if (state.half_pending) begin
        state_next.half_pending = 1'b0;
        state_next.held = '0;
      end else if (size == BYTES_64) begin
        state_next.half_pending = 1'b1;
        state_next.held = in_f;
      end
      if (size == BYTES_NONE) begin
        res.error_code = ERR_INVALID;
      end else if (complete) begin
        res.param_done = 1'b1;
        res.param_bytes = size;
        case (f.para_kind)
          PK_END_LIST: begin
            res.irq_valid = 1'b1;
            res.irq_list = state.list;
            state_next.list = '0;
            state_next.vertex_kind = '0;
          end
          PK_LIST_SET: begin
            res.error_code = ERR_LIST_SET;
          end
          PK_POLY, PK_SPRITE: begin
            if (f.list_kind > LK_LAST) begin
              res.error_code = ERR_INVALID;
            end else begin
              state_next.list = f.list_kind;
              state_next.vertex_kind = vertex_class(f);
            end
          end
          default: begin
          end
        endcase
      end
    end
    res.vertex_kind = state_next.vertex_kind;
  end

endmodule

`default_nettype wire

// File: sv/tile_param_stream_classifier.sv
// Top level of the tile parameter stream classifier.
// Depends on tpsc_pkg, tpsc_in_if, tpsc_out_if and tpsc_step.
//
// Usage: words enter on the chunk channel and one result word per input word
// leaves on the result channel, both with valid/ready handshakes. A chunk word
// is either a list init or the decoded control-word fields of one 32-byte
// chunk of the parameter stream; the result reports parameter completion and
// size, the current vertex type, an end-of-list interrupt and error codes.
// The result is registered: a word accepted at one edge has its result valid
// after that edge. Throughput is one word per cycle, set by the single result
// register that sits after the combinational decode and state update.
// When the receiver stalls, the result register holds its word and the chunk
// channel keeps accepting only while that register is empty or being drained
// in the same cycle. Synchronous reset clears the parse state (no half-received
// parameter, list and vertex type zero) and empties the result register.
`timescale 1ns / 1ps
`default_nettype none

module tile_param_stream_classifier (
  input wire logic  clk,
  input wire logic  rst,
  tpsc_in_if.sink   chunk,
  tpsc_out_if.source result
);
  import tpsc_pkg::*;

  state_t  state;
  state_t  state_next;
  result_t res;
  result_t res_reg;
  logic    res_valid;
  logic    accept;

  assign chunk.ready = !res_valid || result.ready;
  assign accept = chunk.valid && chunk.ready;

  tpsc_step u_step (
    .chunk      (chunk.data),
    .state      (state),
    .state_next (state_next),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
      res_valid <= 1'b0;
    end else if (accept) begin
      state <= state_next;
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_reg <= res;
    end
  end

  assign result.valid = res_valid;
  assign result.data  = res_reg;

endmodule

`default_nettype wire
